FILE: design/udpdmx_pkg.sv
// Shared definitions for the UDP port demultiplexer with per-slot receive rings.
// Holds the default sizes, operation and status codes, and the control structs.
// Depends on nothing; the controller, datapath and top level import it.
`default_nettype none

package udpdmx_pkg;

	localparam int SLOTS_DEF        = 32;
	localparam int QUEUE_DEPTH_DEF  = 8;
	localparam int PACKET_BYTES_DEF = 512;

	localparam logic [1:0] OP_BIND    = 2'd0;
	localparam logic [1:0] OP_CLOSE   = 2'd1;
	localparam logic [1:0] OP_DELIVER = 2'd2;
	localparam logic [1:0] OP_RECEIVE = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_NO_FREE   = 3'd2;
	localparam logic [2:0] ST_PORT_USED = 3'd3;
	localparam logic [2:0] ST_BAD_SLOT  = 3'd4;
	localparam logic [2:0] ST_NO_MATCH  = 3'd5;
	localparam logic [2:0] ST_BAD_ARG   = 3'd6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;      // capture the command fields
		logic       scan;      // register match and free vectors
		logic       pick;      // select the working slot
		logic       claim;     // bind the port to the working slot
		logic       close;
		logic       dlv_start; // begin or continue a delivery
		logic       entry;     // register entry index at ring tail (or head)
		logic       use_head;  // entry index from ring head
		logic       base;      // register payload base address
		logic       dlv_wr1;   // first payload write and merge
		logic       dlv_done;  // optional second payload write, then offset update or packet close
		logic       rcv_len;   // compute receive length
		logic       rcv_rd;    // payload read address phase
		logic       rcv_out;   // emit one received word
		logic       emit;      // emit a single result with code
		logic [2:0] code;
	} udpdmx_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] op;
		logic       port_zero;
		logic       any_match;
		logic       any_free;
		logic       slot_bad;
		logic       max_zero;
		logic       ring_empty;
		logic       dlv_active;
		logic       last_word;
	} udpdmx_stat_t;

endpackage

`default_nettype wire

FILE: design/udpdmx_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the packet entry stores; depends on nothing.
`default_nettype none

module udpdmx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: design/udpdmx_ctrl.sv
// Controller state machine of the UDP port demultiplexer.
// Sequences each command through the datapath; uses udpdmx_pkg.
`default_nettype none

module udpdmx_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire udpdmx_pkg::udpdmx_stat_t stat,
	output udpdmx_pkg::udpdmx_cmd_t       cmd
);
	import udpdmx_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SCAN   = 4'd1;
	localparam logic [3:0] S_PICK   = 4'd2;
	localparam logic [3:0] S_EXEC   = 4'd3;
	localparam logic [3:0] S_DENTRY = 4'd4;
	localparam logic [3:0] S_DBASE  = 4'd5;
	localparam logic [3:0] S_DWR1   = 4'd6;
	localparam logic [3:0] S_DDONE  = 4'd7;
	localparam logic [3:0] S_RMETA  = 4'd8;
	localparam logic [3:0] S_RLEN   = 4'd9;
	localparam logic [3:0] S_RADDR  = 4'd10;
	localparam logic [3:0] S_ROUT   = 4'd11;

	logic [3:0] state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				state_d  = S_PICK;
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_IDLE;
				unique case (stat.op)
					OP_BIND: begin
						cmd.emit = 1'b1;
						if (stat.port_zero) begin
							cmd.code = ST_BAD_ARG;
						end else if (stat.any_match) begin
							cmd.code = ST_PORT_USED;
						end else if (!stat.any_free) begin
							cmd.code = ST_NO_FREE;
						end else begin
							cmd.code  = ST_OK;
							cmd.claim = 1'b1;
						end
					end
					OP_CLOSE: begin
						cmd.emit = 1'b1;
						if (stat.slot_bad) begin
							cmd.code = ST_BAD_SLOT;
						end else begin
							cmd.code  = ST_OK;
							cmd.close = 1'b1;
						end
					end
					OP_DELIVER: begin
						if (!stat.dlv_active && !stat.any_match) begin
							cmd.emit = 1'b1;
							cmd.code = ST_NO_MATCH;
						end else begin
							cmd.dlv_start = 1'b1;
							state_d       = S_DENTRY;
						end
					end
					OP_RECEIVE: begin
						if (stat.slot_bad) begin
							cmd.emit = 1'b1;
							cmd.code = ST_BAD_SLOT;
						end else if (stat.max_zero) begin
							cmd.emit = 1'b1;
							cmd.code = ST_BAD_ARG;
						end else if (stat.ring_empty) begin
							cmd.emit = 1'b1;
							cmd.code = ST_EMPTY;
						end else begin
							cmd.entry    = 1'b1;
							cmd.use_head = 1'b1;
							state_d      = S_RMETA;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_DENTRY: begin
				cmd.entry = 1'b1;
				state_d   = S_DBASE;
			end
			S_DBASE: begin
				cmd.base = 1'b1;
				state_d  = S_DWR1;
			end
			S_DWR1: begin
				cmd.dlv_wr1 = 1'b1;
				state_d     = S_DDONE;
			end
			S_DDONE: begin
				cmd.dlv_done = 1'b1;
				state_d      = S_IDLE;
			end
			S_RMETA: begin
				cmd.base = 1'b1;
				state_d  = S_RLEN;
			end
			S_RLEN: begin
				cmd.rcv_len = 1'b1;
				state_d     = S_RADDR;
			end
			S_RADDR: begin
				cmd.rcv_rd = 1'b1;
				state_d    = S_ROUT;
			end
			S_ROUT: begin
				cmd.rcv_out = 1'b1;
				state_d     = stat.last_word ? S_IDLE : S_RADDR;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

FILE: design/udpdmx_dp.sv
// Datapath of the UDP port demultiplexer: slot table, ring pointers,
// entry stores and result registers. Uses udpdmx_pkg and udpdmx_ram.
`default_nettype none

module udpdmx_dp #(
	parameter int SLOTS        = udpdmx_pkg::SLOTS_DEF,
	parameter int QUEUE_DEPTH  = udpdmx_pkg::QUEUE_DEPTH_DEF,
	parameter int PACKET_BYTES = udpdmx_pkg::PACKET_BYTES_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire udpdmx_pkg::udpdmx_cmd_t cmd,
	output udpdmx_pkg::udpdmx_stat_t     stat,
	input  wire logic [1:0]              op,
	input  wire logic [4:0]              slot,
	input  wire logic [15:0]             port,
	input  wire logic [31:0]             source_address,
	input  wire logic [15:0]             source_port,
	input  wire logic [63:0]             payload_word,
	input  wire logic [3:0]              byte_count,
	input  wire logic                    packet_end,
	input  wire logic [15:0]             max_len,
	output logic                         result_valid,
	output logic [2:0]                   status,
	output logic [4:0]                   slot_out,
	output logic [31:0]                  sender_address,
	output logic [15:0]                  sender_port,
	output logic [63:0]                  data_word,
	output logic [3:0]                   data_bytes,
	output logic                         overwrote_oldest,
	output logic                         last
);
	import udpdmx_pkg::*;

	localparam int WORDS   = (PACKET_BYTES + 7) / 8;
	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IW      = (SLOT_W > 5) ? SLOT_W : 5;
	localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int OFF_W   = $clog2(PACKET_BYTES + 1);
	localparam int ENTRIES = SLOTS * QUEUE_DEPTH;
	localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PAY_D   = ENTRIES * WORDS;
	localparam int PAY_W   = (PAY_D > 1) ? $clog2(PAY_D) : 1;
	localparam int WIDX_W  = (WORDS > 1) ? $clog2(WORDS) : 1;

	// Captured command fields.
	logic [1:0]  op_q;
	logic [4:0]  slot_in_q;
	logic [15:0] port_in_q;
	logic [31:0] saddr_q;
	logic [15:0] sport_q;
	logic [63:0] word_q;
	logic [3:0]  cnt_q;
	logic        end_q;
	logic [15:0] maxlen_q;

	// Slot table and rings.
	logic              in_use_q [SLOTS];
	logic [15:0]       sport_tab_q [SLOTS];
	logic [PTR_W-1:0]  head_q [SLOTS];
	logic [PTR_W-1:0]  tail_q [SLOTS];
	logic [CNT_W-1:0]  count_q [SLOTS];

	logic [SLOTS-1:0]  match_vec_q, free_vec_q;
	logic [SLOT_W-1:0] cur_q;
	logic              slot_range_bad_q;

	logic              active_q;
	logic [SLOT_W-1:0] dlv_slot_q;
	logic [OFF_W-1:0]  off_q;
	logic              first_q, ow_q;

	logic [ENT_W-1:0]  entry_q;
	logic [PAY_W-1:0]  base_q;
	logic [63:0]       acc_q;
	logic              need2_q;
	logic [OFF_W-1:0]  newoff_q;
	logic [OFF_W-1:0]  left_q;
	logic [WIDX_W-1:0] widx_q;

	// Slot index taken from the command's slot field.
	logic [IW-1:0]     slot_ext;
	logic [SLOT_W-1:0] slot_idx;
	assign slot_ext = IW'(slot_in_q);
	assign slot_idx = slot_ext[SLOT_W-1:0];

	// Lowest set bit of the registered match and free vectors.
	logic [SLOT_W-1:0] match_idx, free_idx;
	always_comb begin
		match_idx = '0;
		free_idx  = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (match_vec_q[i]) begin
				match_idx = SLOT_W'(i);
			end
			if (free_vec_q[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
	end

	logic ring_full;
	assign ring_full = (count_q[cur_q] >= CNT_W'(QUEUE_DEPTH));

	assign stat.op         = op_q;
	assign stat.port_zero  = (port_in_q == 16'd0);
	assign stat.any_match  = |match_vec_q;
	assign stat.any_free   = |free_vec_q;
	assign stat.slot_bad   = slot_range_bad_q || !in_use_q[cur_q];
	assign stat.max_zero   = (maxlen_q == 16'd0);
	assign stat.ring_empty = (count_q[cur_q] == '0);
	assign stat.dlv_active = active_q;
	assign stat.last_word  = (left_q <= OFF_W'(8));

	// Byte merge of the incoming word at the current packet offset.
	logic [3:0]       cnt_sat;
	logic [OFF_W:0]   off_sum;
	logic [OFF_W-1:0] newoff;
	logic [OFF_W-1:0] took;
	logic [4:0]       lane_end;
	logic [2:0]       sh;
	logic [127:0]     shifted;
	logic [63:0]      keep, lo;
	logic [PAY_W-1:0] word_addr;

	assign sh       = off_q[2:0];
	assign cnt_sat  = (cnt_q > 4'd8) ? 4'd8 : cnt_q;
	assign off_sum  = (OFF_W + 1)'(off_q) + (OFF_W + 1)'(cnt_sat);
	assign newoff   = (off_sum > (OFF_W + 1)'(PACKET_BYTES)) ? OFF_W'(PACKET_BYTES)
		: off_sum[OFF_W-1:0];
	assign took     = newoff - off_q;
	assign lane_end = 5'(sh) + 5'(took);
	assign shifted  = {64'd0, word_q} << {sh, 3'b000};
	assign word_addr = base_q + PAY_W'(off_q[OFF_W-1:3]);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			keep[i*8 +: 8] = (3'(i) < sh) ? 8'hFF : 8'h00;
		end
	end
	assign lo = (acc_q & keep) | shifted[63:0];

	// Entry stores.
	logic             meta_we, len_we, pay_we;
	logic [47:0]      meta_rd;
	logic [OFF_W-1:0] len_rd;
	logic [63:0]      pay_wdata, pay_rd;
	logic [PAY_W-1:0] pay_waddr, pay_raddr;

	assign meta_we   = cmd.dlv_wr1 && first_q;
	assign len_we    = cmd.dlv_done && end_q;
	assign pay_we    = (cmd.dlv_wr1 && (off_q < OFF_W'(PACKET_BYTES)))
		|| (cmd.dlv_done && need2_q);
	assign pay_wdata = cmd.dlv_done ? acc_q : lo;
	assign pay_waddr = cmd.dlv_done ? word_addr + PAY_W'(1) : word_addr;
	assign pay_raddr = base_q + PAY_W'(widx_q);

	udpdmx_ram #(.WIDTH(48), .DEPTH(ENTRIES)) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (entry_q),
		.wdata ({saddr_q, sport_q}),
		.raddr (entry_q),
		.rdata (meta_rd)
	);

	udpdmx_ram #(.WIDTH(OFF_W), .DEPTH(ENTRIES)) u_len (
		.clk   (clk),
		.we    (len_we),
		.waddr (entry_q),
		.wdata (off_q == newoff_q ? off_q : newoff_q),
		.raddr (entry_q),
		.rdata (len_rd)
	);

	udpdmx_ram #(.WIDTH(64), .DEPTH(PAY_D)) u_payload (
		.clk   (clk),
		.we    (pay_we),
		.waddr (pay_waddr),
		.wdata (pay_wdata),
		.raddr (pay_raddr),
		.rdata (pay_rd)
	);

	// Receive length and output masking.
	logic [OFF_W-1:0] len_lim, rcv_n;
	logic [3:0]       out_bytes;
	logic [63:0]      out_mask;

	assign len_lim   = (len_rd > OFF_W'(PACKET_BYTES)) ? OFF_W'(PACKET_BYTES) : len_rd;
	assign rcv_n     = (16'(len_lim) > maxlen_q) ? OFF_W'(maxlen_q) : len_lim;
	assign out_bytes = (left_q > OFF_W'(8)) ? 4'd8 : left_q[3:0];

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			out_mask[i*8 +: 8] = (4'(i) < out_bytes) ? 8'hFF : 8'h00;
		end
	end

	// Command capture and working registers without reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= op;
			slot_in_q <= slot;
			port_in_q <= port;
			saddr_q   <= source_address;
			sport_q   <= source_port;
			word_q    <= payload_word;
			cnt_q     <= byte_count;
			end_q     <= packet_end;
			maxlen_q  <= max_len;
		end
		if (cmd.scan) begin
			for (int i = 0; i < SLOTS; i++) begin
				match_vec_q[i] <= in_use_q[i] && (sport_tab_q[i] == port_in_q);
				free_vec_q[i]  <= !in_use_q[i];
			end
			slot_range_bad_q <= ((IW + 1)'(slot_in_q) >= (IW + 1)'(SLOTS));
		end
		if (cmd.pick) begin
			unique case (op_q)
				OP_BIND:    cur_q <= free_idx;
				OP_DELIVER: cur_q <= active_q ? dlv_slot_q : match_idx;
				default:    cur_q <= slot_idx;
			endcase
		end
		if (cmd.entry) begin
			entry_q <= ENT_W'(cur_q) * ENT_W'(QUEUE_DEPTH)
				+ ENT_W'(cmd.use_head ? head_q[cur_q] : tail_q[cur_q]);
		end
		if (cmd.base) begin
			base_q <= PAY_W'(entry_q) * PAY_W'(WORDS);
		end
		if (cmd.dlv_wr1) begin
			newoff_q <= newoff;
			need2_q  <= (lane_end > 5'd8);
			if (off_q < OFF_W'(PACKET_BYTES)) begin
				acc_q <= (lane_end >= 5'd8) ? shifted[127:64] : lo;
			end
		end
		if (cmd.rcv_len) begin
			left_q <= rcv_n;
			widx_q <= '0;
		end
		if (cmd.rcv_out) begin
			left_q <= stat.last_word ? '0 : left_q - OFF_W'(8);
			widx_q <= widx_q + WIDX_W'(1);
		end
	end

	// Slot table, rings and delivery state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				in_use_q[i]    <= 1'b0;
				sport_tab_q[i] <= '0;
				head_q[i]      <= '0;
				tail_q[i]      <= '0;
				count_q[i]     <= '0;
			end
			active_q   <= 1'b0;
			dlv_slot_q <= '0;
			off_q      <= '0;
			first_q    <= 1'b0;
			ow_q       <= 1'b0;
		end else begin
			if (cmd.claim || cmd.close) begin
				in_use_q[cur_q]    <= cmd.claim;
				sport_tab_q[cur_q] <= cmd.claim ? port_in_q : 16'd0;
				head_q[cur_q]      <= '0;
				tail_q[cur_q]      <= '0;
				count_q[cur_q]     <= '0;
			end
			if (cmd.close && active_q && (dlv_slot_q == cur_q)) begin
				active_q <= 1'b0;
				off_q    <= '0;
			end
			if (cmd.dlv_start) begin
				first_q <= !active_q;
				ow_q    <= !active_q && ring_full;
				if (!active_q) begin
					active_q   <= 1'b1;
					dlv_slot_q <= cur_q;
					off_q      <= '0;
					// A full ring gives up its oldest packet.
					if (ring_full) begin
						head_q[cur_q]  <= (head_q[cur_q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
							: head_q[cur_q] + PTR_W'(1);
						count_q[cur_q] <= count_q[cur_q] - CNT_W'(1);
					end
				end
			end
			if (cmd.dlv_done) begin
				if (end_q) begin
					tail_q[cur_q]  <= (tail_q[cur_q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
						: tail_q[cur_q] + PTR_W'(1);
					count_q[cur_q] <= count_q[cur_q] + CNT_W'(1);
					active_q       <= 1'b0;
					off_q          <= '0;
				end else begin
					off_q <= newoff_q;
				end
			end
			if (cmd.rcv_out && stat.last_word) begin
				head_q[cur_q]  <= (head_q[cur_q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
					: head_q[cur_q] + PTR_W'(1);
				count_q[cur_q] <= count_q[cur_q] - CNT_W'(1);
			end
		end
	end

	// Result registers: each result is shown for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit || cmd.dlv_done || cmd.rcv_out;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit || cmd.dlv_done || cmd.rcv_out) begin
			status           <= cmd.emit ? cmd.code : ST_OK;
			slot_out         <= '0;
			sender_address   <= '0;
			sender_port      <= '0;
			data_word        <= '0;
			data_bytes       <= '0;
			overwrote_oldest <= 1'b0;
			last             <= 1'b1;
			if (cmd.emit && cmd.claim) begin
				slot_out <= 5'(cur_q);
			end
			if (cmd.dlv_done) begin
				slot_out         <= 5'(cur_q);
				overwrote_oldest <= ow_q;
			end
			if (cmd.rcv_out) begin
				sender_address <= meta_rd[47:16];
				sender_port    <= meta_rd[15:0];
				data_word      <= pay_rd & out_mask;
				data_bytes     <= out_bytes;
				last           <= stat.last_word;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/udp_port_demux_receive_queues_unit.sv
// Top level of the UDP port demultiplexer with per-slot receive rings.
// Joins the controller (udpdmx_ctrl) and the datapath (udpdmx_dp); uses udpdmx_pkg.
//
// A command is taken when start is high and busy is low. Every result is shown for
// exactly one cycle with result_valid high; the receiver cannot stall it, so it must
// take each result as it comes. Bind, close and an unmatched delivery word get their
// result from the execute step. For a delivered word the port match is registered, then
// the ring entry and payload address are formed by two constant multiplies, and up to
// two payload memory writes place the bytes. A receive forms the entry index, payload
// base and length, then returns one word at a time, each after a registered read of the
// single payload memory. The block is ready for the next command in the cycle its final
// result is shown. No clearing pass is needed after reset.
`default_nettype none

module udp_port_demux_receive_queues_unit #(
	parameter int SLOTS        = udpdmx_pkg::SLOTS_DEF,
	parameter int QUEUE_DEPTH  = udpdmx_pkg::QUEUE_DEPTH_DEF,
	parameter int PACKET_BYTES = udpdmx_pkg::PACKET_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  op,
	input  wire logic [4:0]  slot,
	input  wire logic [15:0] port,
	input  wire logic [31:0] source_address,
	input  wire logic [15:0] source_port,
	input  wire logic [63:0] payload_word,
	input  wire logic [3:0]  byte_count,
	input  wire logic        packet_end,
	input  wire logic [15:0] max_len,
	output logic             result_valid,
	output logic [2:0]       status,
	output logic [4:0]       slot_out,
	output logic [31:0]      sender_address,
	output logic [15:0]      sender_port,
	output logic [63:0]      data_word,
	output logic [3:0]       data_bytes,
	output logic             overwrote_oldest,
	output logic             last
);
	import udpdmx_pkg::*;

	udpdmx_cmd_t  cmd;
	udpdmx_stat_t stat;

	udpdmx_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	udpdmx_dp #(
		.SLOTS        (SLOTS),
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.PACKET_BYTES (PACKET_BYTES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.op               (op),
		.slot             (slot),
		.port             (port),
		.source_address   (source_address),
		.source_port      (source_port),
		.payload_word     (payload_word),
		.byte_count       (byte_count),
		.packet_end       (packet_end),
		.max_len          (max_len),
		.result_valid     (result_valid),
		.status           (status),
		.slot_out         (slot_out),
		.sender_address   (sender_address),
		.sender_port      (sender_port),
		.data_word        (data_word),
		.data_bytes       (data_bytes),
		.overwrote_oldest (overwrote_oldest),
		.last             (last)
	);

endmodule

`default_nettype wire
